FILE: sv/rsmv_pkg.sv
// shared types and defaults for the running shifted mean and variance block
`timescale 1ns / 1ps
`default_nettype none
package rsmv_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 8;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ACC,
        PH_SQ,
        PH_MDIV,
        PH_MEAN,
        PH_MULD,
        PH_MULN,
        PH_MULM,
        PH_VDIV,
        PH_SQRT,
        PH_FIN
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   init;
        logic   step;
    } ctl_t;

    typedef struct packed {
        logic n_ge2;
    } sts_t;

endpackage
`default_nettype wire

FILE: sv/rsmv_alu.sv
// shared add/subtract unit, carry out doubles as the no-borrow compare
`timescale 1ns / 1ps
`default_nettype none
module rsmv_alu #(
    parameter int AW = 72
) (
    input  wire logic [AW-1:0] op_a,
    input  wire logic [AW-1:0] op_b,
    input  wire logic          sub,
    output logic [AW-1:0]      sum,
    output logic               carry
);

    logic [AW:0] full;

    // a + b, or a + ~b + 1 for subtract
    assign full  = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{AW{1'b0}}, sub};
    assign sum   = full[AW-1:0];
    assign carry = full[AW];

endmodule
`default_nettype wire

FILE: sv/rsmv_ctrl.sv
// phase sequencer with iteration counter
`timescale 1ns / 1ps
`default_nettype none
module rsmv_ctrl #(
    parameter int SAMPLE_BITS = rsmv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rsmv_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = rsmv_pkg::FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_fire,
    input  wire logic          m_tready,
    input  wire rsmv_pkg::sts_t sts,
    output rsmv_pkg::ctl_t     ctl
);

    localparam int AW = 2 * SAMPLE_BITS + 2 * COUNT_BITS + FRAC_BITS;
    localparam int CW = $clog2(AW + 1);

    rsmv_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    len;
    logic             busy;

    // iteration count of each phase
    always_comb begin
        case (phase_reg)
            rsmv_pkg::PH_SQ:   len = CW'(SAMPLE_BITS);
            rsmv_pkg::PH_MDIV: len = CW'(SAMPLE_BITS + COUNT_BITS + FRAC_BITS);
            rsmv_pkg::PH_MULD: len = CW'(COUNT_BITS);
            rsmv_pkg::PH_MULN: len = CW'(COUNT_BITS);
            rsmv_pkg::PH_MULM: len = CW'(SAMPLE_BITS + COUNT_BITS);
            rsmv_pkg::PH_VDIV: len = CW'(AW);
            rsmv_pkg::PH_SQRT: len = CW'(SAMPLE_BITS + FRAC_BITS);
            default:           len = '0;
        endcase
    end

    assign busy = (phase_reg != rsmv_pkg::PH_IDLE) && (phase_reg != rsmv_pkg::PH_FIN);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (busy) begin
            if (cnt_reg == len) begin
                cnt_next = '0;
                case (phase_reg)
                    rsmv_pkg::PH_ACC:  phase_next = rsmv_pkg::PH_SQ;
                    rsmv_pkg::PH_SQ:   phase_next = rsmv_pkg::PH_MDIV;
                    rsmv_pkg::PH_MDIV: phase_next = rsmv_pkg::PH_MEAN;
                    rsmv_pkg::PH_MEAN: phase_next = sts.n_ge2 ? rsmv_pkg::PH_MULD
                                                              : rsmv_pkg::PH_FIN;
                    rsmv_pkg::PH_MULD: phase_next = rsmv_pkg::PH_MULN;
                    rsmv_pkg::PH_MULN: phase_next = rsmv_pkg::PH_MULM;
                    rsmv_pkg::PH_MULM: phase_next = rsmv_pkg::PH_VDIV;
                    rsmv_pkg::PH_VDIV: phase_next = rsmv_pkg::PH_SQRT;
                    rsmv_pkg::PH_SQRT: phase_next = rsmv_pkg::PH_FIN;
                    default:           phase_next = rsmv_pkg::PH_IDLE;
                endcase
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end else if (phase_reg == rsmv_pkg::PH_IDLE) begin
            if (s_fire) begin
                phase_next = rsmv_pkg::PH_ACC;
            end
        end else begin
            if (m_tready) begin
                phase_next = rsmv_pkg::PH_IDLE;
            end
        end
    end

    // outputs
    always_comb begin
        ctl.phase = phase_reg;
        ctl.init  = busy && (cnt_reg == '0);
        ctl.step  = busy && (cnt_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rsmv_pkg::PH_IDLE;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/running_shifted_mean_variance.sv
// top level: accumulator state and datapath around the shared add/subtract unit
//
// Running mean, sample variance (over n-1) and standard deviation of signed samples
// using the shifted-data method: the first sample after reset is the shift value.
// Results are fixed point with FRAC_BITS fractional bits; divisions floor and the
// root is a floor integer square root. One word is taken at a time and the block
// is busy until its result word has been taken. The square, multiply, divide and
// root phases run on one shared adder, one bit per cycle, after a setup step;
// with n < 2 the phases after the mean are skipped. Once the count reaches
// 2^COUNT_BITS-1 samples are ignored and flagged in m_tuser.
`timescale 1ns / 1ps
`default_nettype none
module running_shifted_mean_variance #(
    parameter int SAMPLE_BITS = rsmv_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = rsmv_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = rsmv_pkg::FRAC_BITS_DEF,
    localparam int SDW = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OBITS = 2 * (SAMPLE_BITS + FRAC_BITS) + (2 * SAMPLE_BITS - 1 + FRAC_BITS)
                           + COUNT_BITS,
    localparam int ODW = ((OBITS + 7) / 8) * 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [SDW-1:0] s_tdata,   // sample
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [ODW-1:0]      m_tdata,   // mean_q8, variance_q8, std_q8, samples_seen
    output logic [1:0]          m_tuser    // variance_valid, count_full
);

    localparam int S    = SAMPLE_BITS;
    localparam int C    = COUNT_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DSW  = S + C + 1;
    localparam int SQW  = 2 * S + C;
    localparam int MAGW = S + C;
    localparam int MW   = S + F;
    localparam int VARW = 2 * S - 1 + F;
    localparam int RW   = S + F;
    localparam int RADW = 2 * (S + F);
    localparam int AW   = 2 * S + 2 * C + F;
    localparam int MPW  = S + C;
    localparam int RMW  = (2 * C + 1 > S + F + 3) ? 2 * C + 1 : S + F + 3;

    rsmv_pkg::ctl_t ctl;
    rsmv_pkg::sts_t sts;

    // architectural state
    logic [C-1:0]           n_reg, n_next;
    logic [S-1:0]           k_reg, k_next;
    logic signed [DSW-1:0]  dsum_reg, dsum_next;
    logic [SQW-1:0]         sq_reg, sq_next;
    logic                   full_reg, full_next;
    // working registers
    logic [S-1:0]           x_reg, x_next;
    logic [AW-1:0]          acc_reg, acc_next;
    logic [AW-1:0]          mcand_reg, mcand_next;
    logic [MPW-1:0]         mpl_reg, mpl_next;
    logic [AW-1:0]          q_reg, q_next;
    logic [RMW-1:0]         rem_reg, rem_next;
    logic [2*C-1:0]         div_reg, div_next;
    logic [RADW-1:0]        rad_reg, rad_next;
    // result registers
    logic [MW-1:0]          mean_reg, mean_next;
    logic [VARW-1:0]        var_reg, var_next;
    logic [RW-1:0]          root_reg, root_next;

    logic [AW-1:0]          alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_carry;

    logic [MAGW-1:0]        mag;
    logic [S-1:0]           keff;
    logic signed [S:0]      d;
    logic [S-1:0]           dm;
    logic [RMW-1:0]         div_sh, sqrt_sh;
    logic [RW+1:0]          trial;
    logic [MW-1:0]          qm, qs;
    logic [VARW-1:0]        var_sat;
    logic                   mul_ph, div_ph;

    rsmv_ctrl #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_tvalid && s_tready),
        .m_tready(m_tready),
        .sts     (sts),
        .ctl     (ctl)
    );

    rsmv_alu #(
        .AW(AW)
    ) u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .carry(alu_carry)
    );

    assign sts.n_ge2 = (n_reg >= C'(2));

    // helper values
    assign mag     = dsum_reg[DSW-1] ? MAGW'(-dsum_reg) : MAGW'(dsum_reg);
    assign keff    = (n_reg == '0) ? x_reg : k_reg;
    assign d       = $signed({x_reg[S-1], x_reg}) - $signed({keff[S-1], keff});
    assign dm      = d[S] ? S'(-d) : S'(d);
    assign div_sh  = {rem_reg[RMW-2:0], q_reg[AW-1]};
    assign sqrt_sh = {rem_reg[RMW-3:0], rad_reg[RADW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign qm      = q_reg[MW-1:0];
    assign qs      = dsum_reg[DSW-1] ? (MW'(0) - (qm + MW'(rem_reg != '0))) : qm;
    assign var_sat = (q_reg[AW-1:VARW] != '0) ? {VARW{1'b1}} : q_reg[VARW-1:0];

    assign mul_ph = (ctl.phase == rsmv_pkg::PH_SQ) || (ctl.phase == rsmv_pkg::PH_MULD)
                 || (ctl.phase == rsmv_pkg::PH_MULN) || (ctl.phase == rsmv_pkg::PH_MULM);
    assign div_ph = (ctl.phase == rsmv_pkg::PH_MDIV) || (ctl.phase == rsmv_pkg::PH_VDIV);

    // operand select for the shared unit
    always_comb begin
        if (div_ph) begin
            alu_a   = AW'(div_sh);
            alu_b   = AW'(div_reg);
            alu_sub = 1'b1;
        end else if (ctl.phase == rsmv_pkg::PH_SQRT) begin
            alu_a   = AW'(sqrt_sh);
            alu_b   = AW'(trial);
            alu_sub = 1'b1;
        end else begin
            alu_a   = acc_reg;
            alu_b   = mcand_reg;
            alu_sub = (ctl.phase == rsmv_pkg::PH_MULM);
        end
    end

    // datapath next values
    always_comb begin
        n_next     = n_reg;
        k_next     = k_reg;
        dsum_next  = dsum_reg;
        sq_next    = sq_reg;
        full_next  = full_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mpl_next   = mpl_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        rad_next   = rad_reg;
        mean_next  = mean_reg;
        var_next   = var_reg;
        root_next  = root_reg;

        if (s_tvalid && s_tready) begin
            x_next = s_tdata[S-1:0];
        end

        if (ctl.init) begin
            case (ctl.phase)
                // fold the sample into count, shift value and diff sum
                rsmv_pkg::PH_ACC: begin
                    if (n_reg == {C{1'b1}}) begin
                        full_next = 1'b1;
                    end else begin
                        full_next = 1'b0;
                        k_next    = keff;
                        n_next    = n_reg + 1'b1;
                        dsum_next = dsum_reg + DSW'(d);
                    end
                end
                // square sum += dm * dm
                rsmv_pkg::PH_SQ: begin
                    acc_next   = AW'(sq_reg);
                    mcand_next = AW'(full_reg ? '0 : dm);
                    mpl_next   = MPW'(full_reg ? '0 : dm);
                end
                // mag << F over n
                rsmv_pkg::PH_MDIV: begin
                    sq_next  = acc_reg[SQW-1:0];
                    q_next   = AW'(mag) << (AW - MAGW);
                    rem_next = '0;
                    div_next = (2*C)'(n_reg);
                end
                // signed mean, clear variance results
                rsmv_pkg::PH_MEAN: begin
                    mean_next = (MW'(k_reg) << F) + qs;
                    var_next  = '0;
                    root_next = '0;
                end
                // n * (n - 1)
                rsmv_pkg::PH_MULD: begin
                    acc_next   = '0;
                    mcand_next = AW'(n_reg);
                    mpl_next   = MPW'(n_reg - 1'b1);
                end
                // n * square sum
                rsmv_pkg::PH_MULN: begin
                    div_next   = acc_reg[2*C-1:0];
                    acc_next   = '0;
                    mcand_next = AW'(sq_reg);
                    mpl_next   = MPW'(n_reg);
                end
                // minus mag * mag
                rsmv_pkg::PH_MULM: begin
                    mcand_next = AW'(mag);
                    mpl_next   = mag;
                end
                rsmv_pkg::PH_VDIV: begin
                    q_next   = acc_reg << F;
                    rem_next = '0;
                end
                rsmv_pkg::PH_SQRT: begin
                    var_next  = var_sat;
                    rad_next  = RADW'(var_sat) << F;
                    rem_next  = '0;
                    root_next = '0;
                end
                default: begin
                end
            endcase
        end else if (ctl.step) begin
            if (mul_ph) begin
                // shift-add multiply step
                if (mpl_reg[0]) begin
                    acc_next = alu_sum;
                end
                mcand_next = mcand_reg << 1;
                mpl_next   = mpl_reg >> 1;
            end else if (div_ph) begin
                // restoring divide step
                rem_next = alu_carry ? alu_sum[RMW-1:0] : div_sh;
                q_next   = {q_reg[AW-2:0], alu_carry};
            end else if (ctl.phase == rsmv_pkg::PH_SQRT) begin
                // digit-by-digit root step
                rem_next  = alu_carry ? alu_sum[RMW-1:0] : sqrt_sh;
                root_next = {root_reg[RW-2:0], alu_carry};
                rad_next  = rad_reg << 2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= '0;
            k_reg    <= '0;
            dsum_reg <= '0;
            sq_reg   <= '0;
            full_reg <= 1'b0;
        end else begin
            n_reg    <= n_next;
            k_reg    <= k_next;
            dsum_reg <= dsum_next;
            sq_reg   <= sq_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mpl_reg   <= mpl_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        rad_reg   <= rad_next;
        mean_reg  <= mean_next;
        var_reg   <= var_next;
        root_reg  <= root_next;
    end

    // stream ports
    assign s_tready = (ctl.phase == rsmv_pkg::PH_IDLE);
    assign m_tvalid = (ctl.phase == rsmv_pkg::PH_FIN);
    assign m_tdata  = ODW'({n_reg, root_reg, var_reg, mean_reg});
    assign m_tuser  = {full_reg, sts.n_ge2};

endmodule
`default_nettype wire
